// ===== design/adclz_pkg.sv =====
// Shared types and constants for the ADC-style LZ block decompressor.
`default_nettype none

package adclz_pkg;

  // History memory geometry
  localparam int unsigned HIST_AW    = 16;
  localparam int unsigned HIST_DEPTH = 65536;

  // Counter width and saturation value
  localparam int unsigned CNT_W   = 19;
  localparam logic [18:0] CNT_SAT = 19'h7FFFF;

  // Hard limit on decoded bytes per block (clamped to the counter range)
  localparam int unsigned MAX_BLOCK_BYTES = 262144;
  localparam int unsigned CAP_MAX_INT =
    (MAX_BLOCK_BYTES > 32'h7FFFF) ? 32'h7FFFF : MAX_BLOCK_BYTES;
  localparam logic [18:0] CAP_MAX = CAP_MAX_INT[18:0];

  // Header decode fields
  localparam int unsigned HDR_LIT_BIT  = 7;
  localparam int unsigned HDR_LONG_BIT = 6;
  localparam logic [6:0]  LIT_LEN_MASK    = 7'h7F;
  localparam logic [5:0]  LONG_LEN_MASK   = 6'h3F;
  localparam logic [1:0]  SHORT_DIST_MASK = 2'h3;
  localparam logic [7:0]  LIT_LEN_BIAS    = 8'd1;
  localparam logic [7:0]  LONG_LEN_BIAS   = 8'd4;
  localparam logic [7:0]  SHORT_LEN_BIAS  = 8'd3;
  localparam logic [7:0]  LONG_DIST_BYTES = 8'd2;

  // Token being parsed
  typedef enum logic [1:0] {
    K_IDLE,
    K_LIT,
    K_SHORT,
    K_LONG
  } kind_t;

  // Decoder sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CP_RD,
    ST_CP_A,
    ST_CP_B
  } state_t;

  // One result transaction
  typedef struct packed {
    logic [18:0] written_count;
    logic [18:0] consumed_count;
    logic        truncated;
    logic        bad_reference;
    logic        cap_stop;
    logic        block_done;
    logic        last_of_run;
    logic [1:0]  out_count;
    logic [7:0]  out_byte_b;
    logic [7:0]  out_byte_a;
  } res_t;

  // History memory access request
  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== design/adc_lz_decompressor.sv =====
// Top level of the ADC-style LZ block decompressor.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  in_      | in_tvalid/in_tready  | in_tdata = data_byte, in_tlast = block_end
//  out_     | out_tvalid/out_tready| out_tdata = decoded pair and status, out_tlast
//  cfg_     | cfg_wr_en            | cfg_wr_data = out_capacity
//
// Headers, distance bytes and literal bytes are accepted only while the output
// register is free. A back-reference is copied pair by pair: ST_CP_RD reads
// the first byte, ST_CP_A writes it and reads the second, ST_CP_B writes it and
// returns the pair; an odd last byte comes from ST_CP_A. Reset is synchronous and
// needs no clearing pass; a stalled output holds the decoder before the next pair.
`default_nettype none

module adc_lz_decompressor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // block_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] out_byte_a, [15:8] out_byte_b, [17:16] out_count, [18] block_done,
  // [19] capacity stop, [20] bad_reference, [21] truncated,
  // [40:22] consumed_count, [59:41] written_count, [63:60] zero
  output logic [63:0]      out_tdata,
  output logic             out_tlast,  // last_of_run
  input  wire logic        cfg_wr_en,
  input  wire logic [18:0] cfg_wr_data // out_capacity
);
  import adclz_pkg::*;

  logic [18:0] out_cap_r;
  logic [18:0] cap;
  logic        out_valid_r;
  res_t        out_res_r;
  logic        out_free;
  logic        res_vld;
  res_t        res;
  mem_req_t    mem_req;
  logic [7:0]  rd_data;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_cap_r <= 19'd262144;
    end else if (cfg_wr_en) begin
      out_cap_r <= cfg_wr_data;
    end
  end

  // Limit in force is the smaller of the register and the block limit
  assign cap = (out_cap_r > CAP_MAX) ? CAP_MAX : out_cap_r;

  assign out_free = !out_valid_r || out_tready;

  adclz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cap       (cap),
    .out_free  (out_free),
    .res_vld   (res_vld),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  adclz_hist_mem u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Output register: load a new result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_res_r <= res;
    end
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.last_of_run;
  assign out_tdata  = {4'b0,
                       out_res_r.written_count,
                       out_res_r.consumed_count,
                       out_res_r.truncated,
                       out_res_r.bad_reference,
                       out_res_r.cap_stop,
                       out_res_r.block_done,
                       out_res_r.out_count,
                       out_res_r.out_byte_b,
                       out_res_r.out_byte_a};

endmodule

`default_nettype wire

// ===== design/adclz_hist_mem.sv =====
// 64 KiB history memory: one write port, one registered read port with forwarding.
`default_nettype none

module adclz_hist_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire adclz_pkg::mem_req_t req,
  output logic [7:0]             rd_data
);
  import adclz_pkg::*;

  logic [7:0] mem [HIST_DEPTH];
  logic [7:0] rdata_r;
  logic [7:0] fwd_data_r;
  logic       fwd_r;

  // Write and read the array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
    fwd_data_r <= req.wdata;
  end

  // Flag a read of the entry written in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= req.re && req.we && (req.raddr == req.waddr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rdata_r;

endmodule

`default_nettype wire

// ===== design/adclz_ctrl.sv =====
// Token parser and copy sequencer: reads, extends and writes the history.
`default_nettype none

module adclz_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [7:0]          in_tdata,
  input  wire logic                in_tlast,
  input  wire logic [18:0]         cap,
  input  wire logic                out_free,
  output logic                     res_vld,
  output adclz_pkg::res_t          res,
  output adclz_pkg::mem_req_t      mem_req,
  input  wire logic [7:0]          rd_data
);
  import adclz_pkg::*;

  state_t      state_r, state_nxt;
  kind_t       kind_r, kind_nxt;
  logic [18:0] written_r, written_nxt;
  logic [18:0] consumed_r, consumed_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic        stopped_r, stopped_nxt;
  logic        err_r, err_nxt;
  logic        end_r, end_nxt;
  logic        bad_a_r, bad_a_nxt;
  logic        bad_b_r, bad_b_nxt;
  logic [7:0]  a_r, a_nxt;

  logic [7:0]  hdr_size;
  logic        hdr_over;
  logic [16:0] dist_p1;
  logic [18:0] pos_next;
  logic        take;
  logic        emit_lit;
  logic        clear;
  logic [7:0]  cur_byte;
  logic        last;

  // Chunk size of a header byte and the capacity check
  always_comb begin
    if (in_tdata[HDR_LIT_BIT]) begin
      hdr_size = {1'b0, in_tdata[6:0] & LIT_LEN_MASK} + LIT_LEN_BIAS;
    end else if (in_tdata[HDR_LONG_BIT]) begin
      hdr_size = {2'b0, in_tdata[5:0] & LONG_LEN_MASK} + LONG_LEN_BIAS;
    end else begin
      hdr_size = {4'b0, in_tdata[5:2]} + SHORT_LEN_BIAS;
    end
  end

  assign hdr_over = ({1'b0, written_r} + {12'b0, hdr_size}) > {1'b0, cap};
  assign dist_p1  = {1'b0, dist_r} + 17'd1;
  assign pos_next = written_r + 19'd1;

  // Next state, memory requests and results
  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    written_nxt  = written_r;
    consumed_nxt = consumed_r;
    left_nxt     = left_r;
    len_nxt      = len_r;
    dist_nxt     = dist_r;
    stopped_nxt  = stopped_r;
    err_nxt      = err_r;
    end_nxt      = end_r;
    bad_a_nxt    = bad_a_r;
    bad_b_nxt    = bad_b_r;
    a_nxt        = a_r;
    in_tready    = 1'b0;
    res_vld      = 1'b0;
    res          = '0;
    mem_req      = '0;
    take         = 1'b0;
    emit_lit     = 1'b0;
    clear        = 1'b0;
    cur_byte     = '0;
    last         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          if (!stopped_r) begin
            unique case (kind_r)
              K_IDLE: begin
                if (hdr_over) begin
                  stopped_nxt = 1'b1;
                end else begin
                  take = 1'b1;
                  if (in_tdata[HDR_LIT_BIT]) begin
                    kind_nxt = K_LIT;
                    left_nxt = hdr_size;
                  end else if (in_tdata[HDR_LONG_BIT]) begin
                    kind_nxt = K_LONG;
                    len_nxt  = hdr_size[6:0];
                    left_nxt = LONG_DIST_BYTES;
                    dist_nxt = '0;
                  end else begin
                    kind_nxt = K_SHORT;
                    len_nxt  = hdr_size[6:0];
                    dist_nxt = {6'b0, in_tdata[1:0] & SHORT_DIST_MASK, 8'b0};
                  end
                end
              end
              K_LIT: begin
                take          = 1'b1;
                emit_lit      = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.waddr = written_r[HIST_AW-1:0];
                mem_req.wdata = in_tdata;
                written_nxt   = pos_next;
                left_nxt      = left_r - 8'd1;
                if (left_r == 8'd1) begin
                  kind_nxt = K_IDLE;
                end
              end
              K_SHORT: begin
                take      = 1'b1;
                dist_nxt  = dist_r | {8'b0, in_tdata};
                kind_nxt  = K_IDLE;
                state_nxt = ST_CP_RD;
              end
              K_LONG: begin
                take = 1'b1;
                if (left_r >= 8'd2) begin
                  dist_nxt = {in_tdata, 8'b0};
                  left_nxt = 8'd1;
                end else begin
                  dist_nxt  = dist_r | {8'b0, in_tdata};
                  left_nxt  = '0;
                  kind_nxt  = K_IDLE;
                  state_nxt = ST_CP_RD;
                end
              end
              default: ;
            endcase
          end
          if (take && (consumed_r != CNT_SAT)) begin
            consumed_nxt = consumed_r + 19'd1;
          end
          end_nxt = in_tlast;
          // Single result for a literal byte or an end-of-block marker
          if (state_nxt == ST_IDLE && (emit_lit || in_tlast)) begin
            res_vld            = 1'b1;
            res.out_byte_a     = emit_lit ? in_tdata : 8'd0;
            res.out_count      = emit_lit ? 2'd1 : 2'd0;
            res.last_of_run    = 1'b1;
            res.block_done     = in_tlast;
            res.cap_stop       = in_tlast && stopped_nxt;
            res.bad_reference  = in_tlast && err_r;
            res.truncated      = in_tlast && !stopped_nxt && (kind_nxt != K_IDLE);
            res.consumed_count = consumed_nxt;
            res.written_count  = written_nxt;
            clear              = in_tlast;
          end
        end
      end

      ST_CP_RD: begin
        // Fetch the first byte of a pair once the output slot is free
        if (out_free) begin
          bad_a_nxt     = written_r < {2'b0, dist_p1};
          mem_req.re    = !bad_a_nxt;
          mem_req.raddr = written_r[HIST_AW-1:0] - dist_r - 16'd1;
          state_nxt     = ST_CP_A;
        end
      end

      ST_CP_A: begin
        cur_byte      = bad_a_r ? 8'd0 : rd_data;
        a_nxt         = cur_byte;
        mem_req.we    = 1'b1;
        mem_req.waddr = written_r[HIST_AW-1:0];
        mem_req.wdata = cur_byte;
        written_nxt   = pos_next;
        len_nxt       = len_r - 7'd1;
        err_nxt       = err_r | bad_a_r;
        if (len_r == 7'd1) begin
          res_vld            = 1'b1;
          res.out_byte_a     = cur_byte;
          res.out_count      = 2'd1;
          res.last_of_run    = 1'b1;
          res.block_done     = end_r;
          res.cap_stop       = end_r && stopped_r;
          res.bad_reference  = bad_a_r || (end_r && err_nxt);
          res.consumed_count = consumed_r;
          res.written_count  = written_nxt;
          clear              = end_r;
          state_nxt          = ST_IDLE;
        end else begin
          // Fetch the second byte; distance one reads the byte written now
          bad_b_nxt     = pos_next < {2'b0, dist_p1};
          mem_req.re    = !bad_b_nxt;
          mem_req.raddr = pos_next[HIST_AW-1:0] - dist_r - 16'd1;
          state_nxt     = ST_CP_B;
        end
      end

      ST_CP_B: begin
        cur_byte      = bad_b_r ? 8'd0 : rd_data;
        last          = (len_r == 7'd1);
        mem_req.we    = 1'b1;
        mem_req.waddr = written_r[HIST_AW-1:0];
        mem_req.wdata = cur_byte;
        written_nxt   = pos_next;
        len_nxt       = len_r - 7'd1;
        err_nxt       = err_r | bad_b_r;
        res_vld            = 1'b1;
        res.out_byte_a     = a_r;
        res.out_byte_b     = cur_byte;
        res.out_count      = 2'd2;
        res.last_of_run    = last;
        res.block_done     = last && end_r;
        res.cap_stop       = last && end_r && stopped_r;
        res.bad_reference  = bad_a_r || bad_b_r || (last && end_r && err_nxt);
        res.consumed_count = consumed_r;
        res.written_count  = written_nxt;
        clear              = last && end_r;
        state_nxt          = last ? ST_IDLE : ST_CP_RD;
      end

      default: ;
    endcase

    // Return block state to its start values after the final result
    if (clear) begin
      written_nxt  = '0;
      consumed_nxt = '0;
      kind_nxt     = K_IDLE;
      left_nxt     = '0;
      len_nxt      = '0;
      dist_nxt     = '0;
      stopped_nxt  = 1'b0;
      err_nxt      = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      kind_r     <= K_IDLE;
      written_r  <= '0;
      consumed_r <= '0;
      left_r     <= '0;
      len_r      <= '0;
      dist_r     <= '0;
      stopped_r  <= 1'b0;
      err_r      <= 1'b0;
      end_r      <= 1'b0;
      bad_a_r    <= 1'b0;
      bad_b_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      kind_r     <= kind_nxt;
      written_r  <= written_nxt;
      consumed_r <= consumed_nxt;
      left_r     <= left_nxt;
      len_r      <= len_nxt;
      dist_r     <= dist_nxt;
      stopped_r  <= stopped_nxt;
      err_r      <= err_nxt;
      end_r      <= end_nxt;
      bad_a_r    <= bad_a_nxt;
      bad_b_r    <= bad_b_nxt;
    end
  end

  // First byte of a pair
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
  end

`ifndef ASSERT_OFF
  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> out_free)
    else $error("result produced while output register is occupied");

  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CP_A || state_r == ST_CP_B) |-> (len_r != 7'd0))
    else $error("copy step with no bytes left");

  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.block_done) |=>
      (written_r == 19'd0 && consumed_r == 19'd0 && kind_r == K_IDLE && !stopped_r))
    else $error("block state not cleared after block end");
`endif

endmodule

`default_nettype wire
